FILE: rtl/blend_file_block_parser_defines.svh
// ----------------------------------------------------------------------------
// blend_file_block_parser_defines
// assertion macros used by the block header parser module bfbp_back
// ----------------------------------------------------------------------------
`ifndef BLEND_FILE_BLOCK_PARSER_DEFINES_SVH
`define BLEND_FILE_BLOCK_PARSER_DEFINES_SVH

// condition implies consequence in the same cycle
`define BFBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define BFBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bfbp_pkg.sv
// ----------------------------------------------------------------------------
// bfbp_pkg
// types, constants and codes of the scene file block header parser
// ----------------------------------------------------------------------------
package bfbp_pkg;

    // default width of the legal data size range
    localparam int unsigned SIZE_BITS_DEFAULT = 31;

    // queue between the classifier and the parser
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // file header layout
    localparam int unsigned MAGIC_LEN   = 7;
    localparam int unsigned VERSION_LEN = 3;
    localparam int unsigned WORD_LEN    = 4;
    localparam int unsigned DWORD_LEN   = 8;
    localparam int unsigned CNT_W       = 4;

    // magic word characters, first character at index zero
    localparam logic [7:0] MAGIC_CHARS [MAGIC_LEN] =
        '{8'h42, 8'h4C, 8'h45, 8'h4E, 8'h44, 8'h45, 8'h52};

    // mode characters
    localparam logic [7:0] CHAR_PTR_NARROW = 8'h5F;  // underscore
    localparam logic [7:0] CHAR_PTR_WIDE   = 8'h2D;  // dash
    localparam logic [7:0] CHAR_END_LITTLE = 8'h76;  // lower-case v
    localparam logic [7:0] CHAR_END_BIG    = 8'h56;  // upper-case v

    // end block code
    localparam logic [31:0] CODE_ENDB = 32'h454E4442;

    // record kinds
    localparam logic [1:0] REC_FILE_HEADER  = 2'd0;
    localparam logic [1:0] REC_BLOCK_HEADER = 2'd1;
    localparam logic [1:0] REC_ERROR        = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ERR_BAD_MODE  = 2'd2;
    localparam logic [1:0] ERR_BAD_SIZE  = 2'd3;

    // parser phases
    typedef enum logic [3:0] {
        PH_MAGIC,
        PH_PTR_CHAR,
        PH_END_CHAR,
        PH_VERSION,
        PH_CODE,
        PH_SIZE,
        PH_POINTER,
        PH_INDEX,
        PH_COUNT,
        PH_DATA,
        PH_HALT
    } phase_t;

    // input transaction
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_item_t;

    // classified byte handed from the front to the parser
    typedef struct packed {
        logic [7:0]           data_byte;
        logic                 start_of_file;
        logic [MAGIC_LEN-1:0] magic_hit;
        logic                 ptr_narrow;
        logic                 ptr_wide;
        logic                 end_little;
        logic                 end_big;
    } byte_class_t;

    // output record
    typedef struct packed {
        logic [1:0]         record_kind;
        logic [31:0]        chunk_code;
        logic [30:0]        data_size;
        logic [63:0]        old_pointer;
        logic signed [31:0] type_index;
        logic signed [31:0] item_count;
        logic               wide_pointers;
        logic               big_endian;
        logic [1:0]         error_code;
        logic               is_end_block;
    } out_item_t;

endpackage

FILE: rtl/bfbp_front.sv
// ----------------------------------------------------------------------------
// bfbp_front
// accepts file bytes and classifies them against the header characters
// ----------------------------------------------------------------------------
module bfbp_front
    import bfbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  in_item_t    byte_item,
    output logic        cls_valid,
    input  logic        cls_stall,
    output byte_class_t cls_item
);

    logic        valid_reg;
    logic        valid_next;
    byte_class_t item_reg;
    byte_class_t item_next;
    logic        accept;

    // stall only while holding a byte the queue cannot take
    assign byte_stall = valid_reg && cls_stall;
    assign accept     = byte_valid && !byte_stall;
    assign cls_valid  = valid_reg;
    assign cls_item   = item_reg;

    // classify the incoming byte
    always_comb
    begin
        item_next               = item_reg;
        valid_next              = valid_reg;
        if (accept)
        begin
            valid_next              = 1'b1;
            item_next.data_byte     = byte_item.data_byte;
            item_next.start_of_file = byte_item.start_of_file;
            for (int k = 0; k < MAGIC_LEN; k++)
            begin
                item_next.magic_hit[k] = (byte_item.data_byte == MAGIC_CHARS[k]);
            end
            item_next.ptr_narrow = (byte_item.data_byte == CHAR_PTR_NARROW);
            item_next.ptr_wide   = (byte_item.data_byte == CHAR_PTR_WIDE);
            item_next.end_little = (byte_item.data_byte == CHAR_END_LITTLE);
            item_next.end_big    = (byte_item.data_byte == CHAR_END_BIG);
        end
        else if (!cls_stall)
        begin
            valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

FILE: rtl/bfbp_queue.sv
// ----------------------------------------------------------------------------
// bfbp_queue
// short queue of classified bytes between the front and the parser
// ----------------------------------------------------------------------------
module bfbp_queue
    import bfbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_stall,
    input  byte_class_t push_item,
    output logic        head_valid,
    input  logic        pop,
    output byte_class_t head_item
);

    byte_class_t            mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_PTR_W:0]   fill_reg;
    logic [QUEUE_PTR_W:0]   fill_next;
    logic                   push;
    logic                   do_pop;

    assign push_stall = (fill_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign push       = push_valid && !push_stall;
    assign head_valid = (fill_reg != '0);
    assign do_pop     = pop && head_valid;
    assign head_item  = mem[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/bfbp_back.sv
// ----------------------------------------------------------------------------
// bfbp_back
// header parser: walks the layout one byte per unstalled cycle into records
// ----------------------------------------------------------------------------
`include "blend_file_block_parser_defines.svh"

module bfbp_back
    import bfbp_pkg::*;
#(
    parameter int unsigned SIZE_BITS = SIZE_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        entry_valid,
    input  byte_class_t entry,
    output logic        entry_pop,
    output logic        rec_valid,
    input  logic        rec_stall,
    output out_item_t   rec_item
);

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [1:0]           off_reg;
    logic [1:0]           off_next;
    logic                 wide_reg;
    logic                 wide_next;
    logic                 big_reg;
    logic                 big_next;
    logic [SIZE_BITS-1:0] skip_reg;
    logic [SIZE_BITS-1:0] skip_next;
    logic [31:0]          code_reg;
    logic [31:0]          code_next;
    logic [31:0]          size_reg;
    logic [31:0]          size_next;
    logic [63:0]          ptr_reg;
    logic [63:0]          ptr_next;
    logic [31:0]          index_reg;
    logic [31:0]          index_next;
    logic [31:0]          count_reg;
    logic [31:0]          count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_item_t            out_reg;
    out_item_t            out_next;

    phase_t               ph_cur;
    logic [CNT_W-1:0]     cnt_cur;
    logic [1:0]           off_cur;
    logic                 wide_cur;
    logic                 big_cur;
    logic [SIZE_BITS-1:0] skip_cur;
    logic [63:0]          acc_sel;
    logic [63:0]          gathered;
    logic                 step;
    logic                 emit;
    out_item_t            rec;

    // one byte of a numeric field in the file's byte order
    function automatic logic [63:0] gather(input logic [63:0] acc, input logic [2:0] n,
                                           input logic [7:0] b, input logic big);
        logic [63:0] base;
        logic [63:0] res;
        base = (n == 3'd0) ? 64'd0 : acc;
        if (big)
        begin
            res = {base[55:0], b};
        end
        else
        begin
            res = base;
            for (int k = 0; k < 8; k++)
            begin
                if (n == 3'(k))
                begin
                    res[8*k +: 8] = b;
                end
            end
        end
        return res;
    endfunction

    // a byte is parsed when the record register can take a result
    assign step      = entry_valid && (!out_valid_reg || !rec_stall);
    assign entry_pop = step;
    assign rec_valid = out_valid_reg;
    assign rec_item  = out_reg;

    // start of file restarts the parse before the byte is taken
    always_comb
    begin
        if (entry.start_of_file)
        begin
            ph_cur   = PH_MAGIC;
            cnt_cur  = '0;
            off_cur  = '0;
            wide_cur = 1'b0;
            big_cur  = 1'b0;
            skip_cur = '0;
        end
        else
        begin
            ph_cur   = phase_reg;
            cnt_cur  = cnt_reg;
            off_cur  = off_reg;
            wide_cur = wide_reg;
            big_cur  = big_reg;
            skip_cur = skip_reg;
        end
    end

    // shared field gather
    always_comb
    begin
        unique case (ph_cur)
            PH_SIZE:    acc_sel = {32'd0, size_reg};
            PH_POINTER: acc_sel = ptr_reg;
            PH_INDEX:   acc_sel = {32'd0, index_reg};
            default:    acc_sel = {32'd0, count_reg};
        endcase
        gathered = gather(acc_sel, cnt_cur[2:0], entry.data_byte, big_cur);
    end

    // parser next state and record
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        off_next   = off_reg;
        wide_next  = wide_reg;
        big_next   = big_reg;
        skip_next  = skip_reg;
        code_next  = code_reg;
        size_next  = size_reg;
        ptr_next   = ptr_reg;
        index_next = index_reg;
        count_next = count_reg;
        emit       = 1'b0;
        rec        = '0;

        if (step)
        begin
            phase_next = ph_cur;
            cnt_next   = cnt_cur;
            off_next   = off_cur + 2'd1;
            wide_next  = wide_cur;
            big_next   = big_cur;
            skip_next  = skip_cur;

            unique case (ph_cur)
                PH_MAGIC:
                begin
                    if (!entry.magic_hit[cnt_cur[2:0]])
                    begin
                        emit            = 1'b1;
                        rec.record_kind = REC_ERROR;
                        rec.error_code  = ERR_BAD_MAGIC;
                        phase_next      = PH_HALT;
                    end
                    else if (cnt_cur == CNT_W'(MAGIC_LEN - 1))
                    begin
                        cnt_next   = '0;
                        phase_next = PH_PTR_CHAR;
                    end
                    else
                    begin
                        cnt_next = cnt_cur + 1'b1;
                    end
                end
                PH_PTR_CHAR:
                begin
                    if (entry.ptr_narrow || entry.ptr_wide)
                    begin
                        wide_next  = entry.ptr_wide;
                        phase_next = PH_END_CHAR;
                    end
                    else
                    begin
                        emit            = 1'b1;
                        rec.record_kind = REC_ERROR;
                        rec.error_code  = ERR_BAD_MODE;
                        phase_next      = PH_HALT;
                    end
                end
                PH_END_CHAR:
                begin
                    if (entry.end_little || entry.end_big)
                    begin
                        big_next   = entry.end_big;
                        cnt_next   = '0;
                        phase_next = PH_VERSION;
                    end
                    else
                    begin
                        wide_next       = 1'b0;
                        emit            = 1'b1;
                        rec.record_kind = REC_ERROR;
                        rec.error_code  = ERR_BAD_MODE;
                        phase_next      = PH_HALT;
                    end
                end
                PH_VERSION:
                begin
                    if (cnt_cur == CNT_W'(VERSION_LEN - 1))
                    begin
                        cnt_next          = '0;
                        phase_next        = PH_CODE;
                        emit              = 1'b1;
                        rec.record_kind   = REC_FILE_HEADER;
                        rec.wide_pointers = wide_cur;
                        rec.big_endian    = big_cur;
                    end
                    else
                    begin
                        cnt_next = cnt_cur + 1'b1;
                    end
                end
                PH_CODE:
                begin
                    // padding up to the next 4-byte file offset
                    if (cnt_cur != '0 || off_cur == 2'd0)
                    begin
                        code_next = {code_reg[23:0], entry.data_byte};
                        if (cnt_cur == CNT_W'(WORD_LEN - 1))
                        begin
                            cnt_next   = '0;
                            phase_next = PH_SIZE;
                        end
                        else
                        begin
                            cnt_next = cnt_cur + 1'b1;
                        end
                    end
                end
                PH_SIZE:
                begin
                    size_next = gathered[31:0];
                    if (cnt_cur == CNT_W'(WORD_LEN - 1))
                    begin
                        cnt_next = '0;
                        if ((gathered[31:0] >> SIZE_BITS) != 32'd0)
                        begin
                            emit              = 1'b1;
                            rec.record_kind   = REC_ERROR;
                            rec.error_code    = ERR_BAD_SIZE;
                            rec.chunk_code    = code_reg;
                            rec.wide_pointers = wide_cur;
                            rec.big_endian    = big_cur;
                            phase_next        = PH_HALT;
                        end
                        else
                        begin
                            phase_next = PH_POINTER;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_cur + 1'b1;
                    end
                end
                PH_POINTER:
                begin
                    ptr_next = gathered;
                    if (cnt_cur == (wide_cur ? CNT_W'(DWORD_LEN - 1) : CNT_W'(WORD_LEN - 1)))
                    begin
                        cnt_next   = '0;
                        phase_next = PH_INDEX;
                    end
                    else
                    begin
                        cnt_next = cnt_cur + 1'b1;
                    end
                end
                PH_INDEX:
                begin
                    index_next = gathered[31:0];
                    if (cnt_cur == CNT_W'(WORD_LEN - 1))
                    begin
                        cnt_next   = '0;
                        phase_next = PH_COUNT;
                    end
                    else
                    begin
                        cnt_next = cnt_cur + 1'b1;
                    end
                end
                PH_COUNT:
                begin
                    count_next = gathered[31:0];
                    if (cnt_cur == CNT_W'(WORD_LEN - 1))
                    begin
                        cnt_next          = '0;
                        emit              = 1'b1;
                        rec.record_kind   = REC_BLOCK_HEADER;
                        rec.chunk_code    = code_reg;
                        rec.data_size     = size_reg[30:0];
                        rec.old_pointer   = ptr_reg;
                        rec.type_index    = index_reg;
                        rec.item_count    = gathered[31:0];
                        rec.wide_pointers = wide_cur;
                        rec.big_endian    = big_cur;
                        rec.error_code    = ERR_NONE;
                        rec.is_end_block  = (code_reg == CODE_ENDB);
                        if (code_reg == CODE_ENDB)
                        begin
                            phase_next = PH_HALT;
                        end
                        else if (size_reg == 32'd0)
                        begin
                            phase_next = PH_CODE;
                        end
                        else
                        begin
                            skip_next  = size_reg[SIZE_BITS-1:0];
                            phase_next = PH_DATA;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_cur + 1'b1;
                    end
                end
                PH_DATA:
                begin
                    if (skip_cur != '0)
                    begin
                        skip_next = skip_cur - 1'b1;
                    end
                    if (skip_cur <= SIZE_BITS'(1))
                    begin
                        phase_next = PH_CODE;
                    end
                end
                default:
                begin
                    // halted until the next start of file
                    phase_next = PH_HALT;
                end
            endcase
        end
    end

    // record register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (step && emit)
        begin
            out_valid_next = 1'b1;
            out_next       = rec;
        end
        else if (!rec_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MAGIC;
            cnt_reg       <= '0;
            off_reg       <= '0;
            wide_reg      <= 1'b0;
            big_reg       <= 1'b0;
            skip_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            off_reg       <= off_next;
            wide_reg      <= wide_next;
            big_reg       <= big_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // field shift registers and record payload
    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        size_reg  <= size_next;
        ptr_reg   <= ptr_next;
        index_reg <= index_next;
        count_reg <= count_next;
        out_reg   <= out_next;
    end

    // checks
    `BFBP_ASSERT_NEXT(a_error_halts, clk, rst_n, step && emit && rec.record_kind == REC_ERROR, phase_reg == PH_HALT, "error record left the parser running")
    `BFBP_ASSERT_NOW(a_halt_silent, clk, rst_n, step && phase_reg == PH_HALT && !entry.start_of_file, !emit, "record produced while halted")
    `BFBP_ASSERT_NOW(a_data_nonzero, clk, rst_n, phase_reg == PH_DATA, skip_reg != '0, "data phase with nothing left to skip")

endmodule

FILE: rtl/blend_file_block_parser.sv
// path: the last byte of a record passes the front register and the queue before bfbp_back registers the record
// throughput: one byte per cycle while no stall holds the parser, set by the parser step in bfbp_back
// a four-entry queue lets the byte side keep going while a record waits to be taken
// reset: asynchronous, active low; clears control state and starts at the magic check
// no clearing pass after reset; start_of_file restarts the parse on any byte
// ----------------------------------------------------------------------------
// blend_file_block_parser
// scene file block header parser: byte stream in, header records out
// ----------------------------------------------------------------------------
module blend_file_block_parser
    import bfbp_pkg::*;
#(
    parameter int unsigned SIZE_BITS = SIZE_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_item_t  byte_item,
    output logic      record_valid,
    input  logic      record_stall,
    output out_item_t record_item
);

    logic        cls_valid;
    logic        cls_stall;
    byte_class_t cls_item;
    logic        head_valid;
    logic        head_pop;
    byte_class_t head_item;

    // byte intake and classification
    bfbp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .cls_valid  (cls_valid),
        .cls_stall  (cls_stall),
        .cls_item   (cls_item)
    );

    // decoupling queue
    bfbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cls_valid),
        .push_stall (cls_stall),
        .push_item  (cls_item),
        .head_valid (head_valid),
        .pop        (head_pop),
        .head_item  (head_item)
    );

    // parser and record register
    bfbp_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (head_valid),
        .entry       (head_item),
        .entry_pop   (head_pop),
        .rec_valid   (record_valid),
        .rec_stall   (record_stall),
        .rec_item    (record_item)
    );

endmodule
